// File: rtl/core/swarq_pkg.sv
// Shared constants and codes for the sliding-window retransmission sender.
`default_nettype none
package swarq_pkg;

	// Window and packet limits
	localparam int WINDOW_SLOTS = 32;
	localparam int MAX_PAYLOAD  = 1400;
	localparam int MAX_RESULTS  = 32;

	// Derived widths
	localparam int SLOT_W  = $clog2(WINDOW_SLOTS);
	localparam int CNT_W   = $clog2(WINDOW_SLOTS + 1);
	localparam int RES_W   = $clog2(MAX_RESULTS);
	localparam int SEQ_W   = 16;
	localparam int SIZE_W  = 11;
	localparam int MAP_W   = 32;
	localparam int TOTAL_W = 32;
	localparam int KIND_W  = 2;
	localparam int OKIND_W = 3;

	// Input item kinds
	localparam logic [KIND_W-1:0] KIND_SEND    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ACK     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_FINISH  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_TIMEOUT = 2'd3;

	// Result kinds
	localparam logic [OKIND_W-1:0] OUT_TX       = 3'd0;
	localparam logic [OKIND_W-1:0] OUT_RETX     = 3'd1;
	localparam logic [OKIND_W-1:0] OUT_REFUSED  = 3'd2;
	localparam logic [OKIND_W-1:0] OUT_FINISHED = 3'd3;
	localparam logic [OKIND_W-1:0] OUT_STATUS   = 3'd4;

endpackage
`default_nettype wire

// File: rtl/core/swarq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module swarq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: rtl/core/sliding_window_arq_sender.sv
// Sender side of a sliding-window retransmission protocol: window, slot sizes, byte total.
//
// Results leave as one-cycle beats on result_valid and cannot be held off by the receiver,
// so any consumer must take every beat as it comes. A send request, a finish notice, or any
// item after the finish is taken while busy is low, and its single result appears the next
// cycle. An acknowledgement keeps busy high while it retires the slots it covers (one
// slot-size RAM read per cycle, summed into the total) and then scans the window for
// packets to retransmit (one position per cycle on the same RAM port). A timeout tick runs
// the same scan. Slot sizes live in one RAM with a registered read; the retire loop and
// the scan share its single read port.
`default_nettype none
module sliding_window_arq_sender (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [swarq_pkg::KIND_W-1:0]     kind,
	input  wire logic [swarq_pkg::SIZE_W-1:0]     payload_size,
	input  wire logic [swarq_pkg::SEQ_W-1:0]      ack_seq,
	input  wire logic [swarq_pkg::MAP_W-1:0]      received_map,
	output logic                                  result_valid,
	output logic      [swarq_pkg::OKIND_W-1:0]    out_kind,
	output logic      [swarq_pkg::SEQ_W-1:0]      out_seq,
	output logic      [swarq_pkg::SIZE_W-1:0]     out_size,
	output logic      [swarq_pkg::TOTAL_W-1:0]    delivered_bytes,
	output logic                                  last
);

	localparam int W = swarq_pkg::WINDOW_SLOTS;
	localparam int SW = swarq_pkg::SLOT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_PREP,
		ST_SCAN
	} state_t;

	state_t state_q;

	// Architectural state
	logic [swarq_pkg::SEQ_W-1:0]   base_q;
	logic [swarq_pkg::SEQ_W-1:0]   next_q;
	logic [SW-1:0]                 head_q;
	logic [W-1:0]                  valid_q;
	logic [swarq_pkg::TOTAL_W-1:0] total_q;
	logic                          fin_q;

	// Per-item working registers
	logic [swarq_pkg::MAP_W-1:0]   map_q;
	logic                          is_ack_q;
	logic [swarq_pkg::CNT_W-1:0]   pop_left_q;
	logic [W-1:0]                  cand_q;
	logic                          any_q;
	logic [SW-1:0]                 pos_q;
	logic [swarq_pkg::RES_W-1:0]   emit_q;

	// Read pipeline stage
	logic                          pop_s1;
	logic                          rd_s1;
	logic [swarq_pkg::SEQ_W-1:0]   seq_s1;
	logic                          last_s1;

	// Result register
	logic                          res_valid_q;
	logic [swarq_pkg::OKIND_W-1:0] res_kind_q;
	logic [swarq_pkg::SEQ_W-1:0]   res_seq_q;
	logic [swarq_pkg::SIZE_W-1:0]  res_size_q;
	logic [swarq_pkg::TOTAL_W-1:0] res_total_q;
	logic                          res_last_q;

	// RAM ports
	logic                          ram_we;
	logic [SW-1:0]                 ram_waddr;
	logic [SW-1:0]                 ram_raddr;
	logic [swarq_pkg::SIZE_W-1:0]  ram_rdata;

	// Derived combinational values
	logic                          accept;
	logic [swarq_pkg::SEQ_W-1:0]   count;
	logic                          full;
	logic                          refuse;
	logic [swarq_pkg::SEQ_W-1:0]   ahead;
	logic [swarq_pkg::SEQ_W-1:0]   pops;
	logic [W-1:0]                  cand;
	logic [W-1:0]                  cand_next;
	logic                          cap_hit;
	logic [swarq_pkg::TOTAL_W:0]   sum;

	// Ring index: head plus offset, wrapped to the window size
	function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
		logic [SW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (SW+1)'(W)) begin
			s = s - (SW+1)'(W);
		end
		return s[SW-1:0];
	endfunction

	assign busy     = (state_q != ST_IDLE) || rd_s1;
	assign accept   = start && !busy;
	assign count    = next_q - base_q;
	assign full     = count >= swarq_pkg::SEQ_W'(W);
	assign refuse   = full || (payload_size > swarq_pkg::SIZE_W'(swarq_pkg::MAX_PAYLOAD));
	assign ahead    = ack_seq - base_q;
	assign pops     = ahead[swarq_pkg::SEQ_W-1] ? '0 : ((ahead > count) ? count : ahead);
	assign cand_next = cand_q >> 1;
	assign cap_hit  = emit_q == swarq_pkg::RES_W'(swarq_pkg::MAX_RESULTS - 1);
	assign sum      = {1'b0, total_q} + {{(swarq_pkg::TOTAL_W + 1 - swarq_pkg::SIZE_W){1'b0}},
		ram_rdata};

	// Store the size of an accepted send in the next free slot
	assign ram_we    = accept && !fin_q && (kind == swarq_pkg::KIND_SEND) && !refuse;
	assign ram_waddr = slot_add(head_q, count[SW-1:0]);
	assign ram_raddr = (state_q == ST_POP) ? head_q : slot_add(head_q, pos_q);

	// Mark window positions that need a retransmit
	always_comb begin
		for (int i = 0; i < W; i++) begin
			cand[i] = (swarq_pkg::SEQ_W'(i) < count)
				&& valid_q[slot_add(head_q, SW'(i))]
				&& !(is_ack_q && (i < swarq_pkg::MAP_W) && map_q[i % swarq_pkg::MAP_W]);
		end
	end

	swarq_ram #(
		.WIDTH(swarq_pkg::SIZE_W),
		.DEPTH(W)
	) u_size_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(payload_size),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer, window state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q      <= '0;
			next_q      <= '0;
			head_q      <= '0;
			valid_q     <= '0;
			total_q     <= '0;
			fin_q       <= 1'b0;
			map_q       <= '0;
			is_ack_q    <= 1'b0;
			pop_left_q  <= '0;
			cand_q      <= '0;
			any_q       <= 1'b0;
			pos_q       <= '0;
			emit_q      <= '0;
			pop_s1      <= 1'b0;
			rd_s1       <= 1'b0;
			seq_s1      <= '0;
			last_s1     <= 1'b0;
			res_valid_q <= 1'b0;
			res_kind_q  <= '0;
			res_seq_q   <= '0;
			res_size_q  <= '0;
			res_total_q <= '0;
			res_last_q  <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			pop_s1      <= 1'b0;
			rd_s1       <= 1'b0;

			// Accumulate retired slot sizes, saturating
			if (pop_s1) begin
				total_q <= sum[swarq_pkg::TOTAL_W] ? '1 : sum[swarq_pkg::TOTAL_W-1:0];
			end

			// Emit a retransmit beat once its size is read
			if (rd_s1) begin
				res_valid_q <= 1'b1;
				res_kind_q  <= swarq_pkg::OUT_RETX;
				res_seq_q   <= seq_s1;
				res_size_q  <= ram_rdata;
				res_total_q <= total_q;
				res_last_q  <= last_s1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (fin_q) begin
							res_valid_q <= 1'b1;
							res_kind_q  <= swarq_pkg::OUT_FINISHED;
							res_seq_q   <= base_q;
							res_size_q  <= '0;
							res_total_q <= total_q;
							res_last_q  <= 1'b1;
						end else begin
							case (kind)
								swarq_pkg::KIND_SEND: begin
									res_valid_q <= 1'b1;
									res_seq_q   <= next_q;
									res_total_q <= total_q;
									res_last_q  <= 1'b1;
									if (refuse) begin
										res_kind_q <= swarq_pkg::OUT_REFUSED;
										res_size_q <= '0;
									end else begin
										res_kind_q          <= swarq_pkg::OUT_TX;
										res_size_q          <= payload_size;
										valid_q[ram_waddr] <= 1'b1;
										next_q              <= next_q + 1'b1;
									end
								end
								swarq_pkg::KIND_FINISH: begin
									fin_q       <= 1'b1;
									res_valid_q <= 1'b1;
									res_kind_q  <= swarq_pkg::OUT_FINISHED;
									res_seq_q   <= base_q;
									res_size_q  <= '0;
									res_total_q <= total_q;
									res_last_q  <= 1'b1;
								end
								swarq_pkg::KIND_ACK: begin
									map_q      <= received_map;
									is_ack_q   <= 1'b1;
									pop_left_q <= pops[swarq_pkg::CNT_W-1:0];
									state_q    <= (pops != '0) ? ST_POP : ST_PREP;
								end
								default: begin
									is_ack_q <= 1'b0;
									state_q  <= ST_PREP;
								end
							endcase
						end
					end
				end
				ST_POP: begin
					// Retire the head slot and advance the window
					pop_s1          <= 1'b1;
					valid_q[head_q] <= 1'b0;
					head_q          <= slot_add(head_q, SW'(1));
					base_q          <= base_q + 1'b1;
					pop_left_q      <= pop_left_q - 1'b1;
					if (pop_left_q == swarq_pkg::CNT_W'(1)) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					cand_q  <= cand;
					any_q   <= |cand;
					pos_q   <= '0;
					emit_q  <= '0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!any_q) begin
						// Nothing to resend: an acknowledgement reports status
						if (is_ack_q) begin
							res_valid_q <= 1'b1;
							res_kind_q  <= swarq_pkg::OUT_STATUS;
							res_seq_q   <= base_q;
							res_size_q  <= '0;
							res_total_q <= total_q;
							res_last_q  <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else begin
						// Walk one window position per cycle
						if (cand_q[0]) begin
							rd_s1   <= 1'b1;
							seq_s1  <= base_q + {{(swarq_pkg::SEQ_W - SW){1'b0}}, pos_q};
							last_s1 <= (cand_next == '0) || cap_hit;
							emit_q  <= emit_q + 1'b1;
						end
						cand_q <= cand_next;
						pos_q  <= pos_q + 1'b1;
						if ((cand_next == '0) || (cand_q[0] && cap_hit)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid    = res_valid_q;
	assign out_kind        = res_kind_q;
	assign out_seq         = res_seq_q;
	assign out_size        = res_size_q;
	assign delivered_bytes = res_total_q;
	assign last            = res_last_q;

endmodule
`default_nettype wire

// File: rtl/core/swarq_checker.sv
// Port-level checks for the sliding-window sender, bound to the top level.
`default_nettype none
module swarq_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             start,
	input wire logic                             busy,
	input wire logic [swarq_pkg::KIND_W-1:0]     kind,
	input wire logic                             result_valid,
	input wire logic [swarq_pkg::OKIND_W-1:0]    out_kind,
	input wire logic [swarq_pkg::SIZE_W-1:0]     out_size,
	input wire logic [swarq_pkg::TOTAL_W-1:0]    delivered_bytes,
	input wire logic                             last
);

	// A send or finish beat always answers with exactly one final result
	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (kind == swarq_pkg::KIND_SEND || kind == swarq_pkg::KIND_FINISH)
		|=> result_valid && last)
	else $error("send or finish did not produce a final result next cycle");

	// Transmit, refused and finished results close their item
	a_single_kinds_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (out_kind == swarq_pkg::OUT_TX || out_kind == swarq_pkg::OUT_REFUSED
		|| out_kind == swarq_pkg::OUT_FINISHED) |-> last)
	else $error("single-result kind without last");

	// Results that carry no packet report a zero size
	a_zero_size: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (out_kind == swarq_pkg::OUT_REFUSED
		|| out_kind == swarq_pkg::OUT_FINISHED || out_kind == swarq_pkg::OUT_STATUS)
		|-> out_size == '0)
	else $error("non-packet result with nonzero size");

	// The delivered total never falls between back-to-back results
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && $past(result_valid) |-> delivered_bytes >= $past(delivered_bytes))
	else $error("delivered byte total decreased");

endmodule

bind sliding_window_arq_sender swarq_checker u_swarq_checker (.*);
`default_nettype wire

// File: tb/testbench.sv
// Self-checking bench for the sliding-window sender: directed table, shaped random beats.
module testbench;
	import swarq_pkg::*;

	// One result beat as the block presents it
	typedef struct packed {
		logic [OKIND_W-1:0] kind;
		logic [SEQ_W-1:0]   seq;
		logic [SIZE_W-1:0]  size;
		logic [TOTAL_W-1:0] total;
		logic               last;
	} beat_t;

	// One stimulus row; want holds a hand-typed result when typed is set
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SIZE_W-1:0] size;
		logic [SEQ_W-1:0]  ack;
		logic [MAP_W-1:0]  map;
		logic              typed;
		beat_t             want;
	} row_t;

	localparam int PLAN_ROWS    = 21;
	localparam int OPEN_ROWS    = 16;
	localparam int RANDOM_ITEMS = 480;
	localparam int TAIL_CYCLES  = 80;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [KIND_W-1:0]  kind;
	logic [SIZE_W-1:0]  payload_size;
	logic [SEQ_W-1:0]   ack_seq;
	logic [MAP_W-1:0]   received_map;
	logic               result_valid;
	logic [OKIND_W-1:0] out_kind;
	logic [SEQ_W-1:0]   out_seq;
	logic [SIZE_W-1:0]  out_size;
	logic [TOTAL_W-1:0] delivered_bytes;
	logic               last;

	// Shadow window state
	logic [SEQ_W-1:0]        arq_base;
	logic [SEQ_W-1:0]        arq_next;
	logic [SLOT_W-1:0]       arq_head;
	logic [WINDOW_SLOTS-1:0] arq_live;
	logic [SIZE_W-1:0]       arq_len [WINDOW_SLOTS];
	logic [TOTAL_W-1:0]      arq_total;
	logic                    arq_done;

	beat_t step_beats [MAX_RESULTS];
	int    step_count;
	beat_t beats_due [$];
	row_t  plan [PLAN_ROWS];
	int    mismatch_count = 0;

	sliding_window_arq_sender dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.payload_size    (payload_size),
		.ack_seq         (ack_seq),
		.received_map    (received_map),
		.result_valid    (result_valid),
		.out_kind        (out_kind),
		.out_seq         (out_seq),
		.out_size        (out_size),
		.delivered_bytes (delivered_bytes),
		.last            (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Hard stop in case a beat never shows up
	initial begin
		#6_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	task automatic note_mismatch(input string what, input beat_t want, input beat_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%s: expected kind=%0d seq=%0d size=%0d total=%0d last=%0d, got kind=%0d seq=%0d size=%0d total=%0d last=%0d",
				what, want.kind, want.seq, want.size, want.total, want.last,
				got.kind, got.seq, got.size, got.total, got.last);
	endtask

	// Append one beat for the current item, capped at the per-item result limit
	task automatic add_beat(input logic [OKIND_W-1:0] k, input logic [SEQ_W-1:0] s,
			input logic [SIZE_W-1:0] z);
		if (step_count < MAX_RESULTS) begin
			step_beats[step_count] = '{k, s, z, arq_total, 1'b0};
			step_count++;
		end
	endtask

	// Advance the shadow window by one accepted item and list the beats it causes
	task automatic predict_step(input row_t r);
		logic [SEQ_W-1:0]   cnt;
		logic [SEQ_W-1:0]   ahead;
		logic [SEQ_W-1:0]   pops;
		logic [SLOT_W-1:0]  slot;
		logic [TOTAL_W:0]   sum;
		logic [SIZE_W-1:0]  sz;
		int unsigned        i;
		step_count = 0;
		cnt = arq_next - arq_base;
		if (arq_done) begin
			add_beat(OUT_FINISHED, arq_base, '0);
		end else begin
			case (r.kind)
				KIND_SEND: begin
					if (cnt >= WINDOW_SLOTS || r.size > MAX_PAYLOAD) begin
						add_beat(OUT_REFUSED, arq_next, '0);
					end else begin
						slot = arq_head + cnt[SLOT_W-1:0];
						arq_live[slot] = 1'b1;
						arq_len[slot] = r.size;
						add_beat(OUT_TX, arq_next, r.size);
						arq_next = arq_next + 1'b1;
					end
				end
				KIND_FINISH: begin
					arq_done = 1'b1;
					add_beat(OUT_FINISHED, arq_base, '0);
				end
				KIND_ACK: begin
					// retire up to the cumulative sequence, never past next
					ahead = r.ack - arq_base;
					pops = ahead[SEQ_W-1] ? '0 : ahead;
					if (pops > cnt)
						pops = cnt;
					for (i = 0; i < pops; i++) begin
						sz = arq_live[arq_head] ? arq_len[arq_head] : '0;
						sum = {1'b0, arq_total} + sz;
						arq_total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
						arq_live[arq_head] = 1'b0;
						arq_head = arq_head + 1'b1;
						arq_base = arq_base + 1'b1;
					end
					// resend what the bitmap leaves clear
					cnt = arq_next - arq_base;
					for (i = 0; i < cnt; i++) begin
						slot = arq_head + i[SLOT_W-1:0];
						if (!(i < MAP_W && r.map[i]) && arq_live[slot])
							add_beat(OUT_RETX, arq_base + i[SEQ_W-1:0], arq_len[slot]);
					end
					if (step_count == 0)
						add_beat(OUT_STATUS, arq_base, '0);
				end
				default: begin
					for (i = 0; i < cnt; i++) begin
						slot = arq_head + i[SLOT_W-1:0];
						if (arq_live[slot])
							add_beat(OUT_RETX, arq_base + i[SEQ_W-1:0], arq_len[slot]);
					end
				end
			endcase
		end
		if (step_count != 0)
			step_beats[step_count-1].last = 1'b1;
	endtask

	// Drive one item from a falling edge, hold it until accepted, queue its beats
	task automatic issue_item(input row_t r, input int unsigned idle_pct);
		int unsigned k;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < idle_pct);
		end
		start        <= 1'b1;
		kind         <= r.kind;
		payload_size <= r.size;
		ack_seq      <= r.ack;
		received_map <= r.map;
		do @(posedge clk); while (busy);
		predict_step(r);
		if (r.typed)
			beats_due.push_back(r.want);
		else
			for (k = 0; k < step_count; k++)
				beats_due.push_back(step_beats[k]);
		@(negedge clk);
	endtask

	// Compare every result beat with the oldest one due
	always @(posedge clk) begin
		beat_t got;
		beat_t want;
		if (arst_n && result_valid) begin
			got = '{out_kind, out_seq, out_size, delivered_bytes, last};
			if (beats_due.size() == 0) begin
				note_mismatch("unexpected beat", '0, got);
			end else begin
				want = beats_due.pop_front();
				if (got.kind !== want.kind || got.seq !== want.seq || got.size !== want.size
						|| got.total !== want.total || got.last !== want.last)
					note_mismatch("wrong beat", want, got);
			end
		end
	end

	initial begin
		row_t             row;
		int unsigned      fruitful;
		int unsigned      sends_left;
		int unsigned      idle_pct;
		int unsigned      pick;
		int               n;
		logic [SEQ_W-1:0] span;

		arst_n       = 1'b0;
		start        = 1'b0;
		kind         = '0;
		payload_size = '0;
		ack_seq      = '0;
		received_map = '0;

		arq_base  = '0;
		arq_next  = '0;
		arq_head  = '0;
		arq_live  = '0;
		arq_total = '0;
		arq_done  = 1'b0;
		for (n = 0; n < WINDOW_SLOTS; n++)
			arq_len[n] = '0;

		// Opening rows: empty window, size limits, retire and resend paths
		plan[0]  = '{KIND_ACK, 11'd0, 16'd0, 32'd0, 1'b1,
			'{OUT_STATUS, 16'd0, 11'd0, 32'd0, 1'b1}};
		plan[1]  = '{KIND_TIMEOUT, 11'd2047, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0};
		plan[2]  = '{KIND_SEND, 11'd1401, 16'd0, 32'd0, 1'b1,
			'{OUT_REFUSED, 16'd0, 11'd0, 32'd0, 1'b1}};
		plan[3]  = '{KIND_SEND, 11'd2047, 16'hFFFF, 32'hFFFF_FFFF, 1'b1,
			'{OUT_REFUSED, 16'd0, 11'd0, 32'd0, 1'b1}};
		plan[4]  = '{KIND_SEND, 11'd0, 16'd0, 32'd0, 1'b1,
			'{OUT_TX, 16'd0, 11'd0, 32'd0, 1'b1}};
		plan[5]  = '{KIND_SEND, 11'd1400, 16'd0, 32'd0, 1'b1,
			'{OUT_TX, 16'd1, 11'd1400, 32'd0, 1'b1}};
		plan[6]  = '{KIND_SEND, 11'd1, 16'h5555, 32'hAAAA_AAAA, 1'b0, '0};
		plan[7]  = '{KIND_SEND, 11'd700, 16'hAAAA, 32'h5555_5555, 1'b0, '0};
		plan[8]  = '{KIND_TIMEOUT, 11'd0, 16'd0, 32'd0, 1'b0, '0};
		plan[9]  = '{KIND_ACK, 11'd0, 16'd1, 32'd0, 1'b0, '0};
		plan[10] = '{KIND_ACK, 11'd2047, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0};
		plan[11] = '{KIND_ACK, 11'd0, 16'd2, 32'h0000_0002, 1'b0, '0};
		plan[12] = '{KIND_ACK, 11'd0, 16'h8000, 32'd0, 1'b0, '0};
		plan[13] = '{KIND_SEND, 11'd2047, 16'd0, 32'd0, 1'b0, '0};
		plan[14] = '{KIND_TIMEOUT, 11'd1400, 16'h1234, 32'h8000_0001, 1'b0, '0};
		plan[15] = '{KIND_ACK, 11'd0, 16'h7FFF, 32'h0F0F_0F0F, 1'b0, '0};
		// Closing rows: finish, then every kind after it
		plan[16] = '{KIND_FINISH, 11'd0, 16'd0, 32'd0, 1'b0, '0};
		plan[17] = '{KIND_SEND, 11'd5, 16'd0, 32'd0, 1'b0, '0};
		plan[18] = '{KIND_ACK, 11'd0, 16'hFFFF, 32'd0, 1'b0, '0};
		plan[19] = '{KIND_TIMEOUT, 11'd0, 16'd0, 32'd0, 1'b0, '0};
		plan[20] = '{KIND_FINISH, 11'd2047, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (n = 0; n < OPEN_ROWS; n++)
			issue_item(plan[n], 18);

		// Random part: send bursts that often fill the window, then acks and timeouts
		fruitful   = 0;
		sends_left = $urandom_range(40, 1);
		while (fruitful < RANDOM_ITEMS) begin
			idle_pct = (fruitful < RANDOM_ITEMS / 3) ? 18 :
				(fruitful < 2 * RANDOM_ITEMS / 3) ? 69 : 0;
			row = '0;
			row.size = ($urandom_range(9) == 0) ? 11'($urandom_range(2047, 1401)) :
				11'($urandom_range(1400));
			row.ack = 16'($urandom);
			row.map = $urandom;
			if (sends_left != 0) begin
				row.kind = KIND_SEND;
				sends_left--;
			end else begin
				if ($urandom_range(99) < 70) begin
					row.kind = KIND_ACK;
					span = arq_next - arq_base;
					pick = $urandom_range(99);
					if (pick < 70)
						row.ack = arq_base + 16'($urandom_range(span));
					else if (pick < 80)
						row.ack = arq_base - 16'($urandom_range(32768, 1));
					else if (pick < 90)
						row.ack = arq_next + 16'($urandom_range(200, 1));
					pick = $urandom_range(99);
					if (pick < 20)
						row.map = $urandom & $urandom;
					else if (pick < 40)
						row.map = $urandom | $urandom;
					else if (pick < 50)
						row.map = '1;
					else if (pick < 60)
						row.map = '0;
				end else begin
					row.kind = KIND_TIMEOUT;
				end
				if ($urandom_range(99) < 30)
					sends_left = $urandom_range(40, 1);
			end
			issue_item(row, idle_pct);
			if (step_count != 0)
				fruitful++;
		end

		for (n = OPEN_ROWS; n < PLAN_ROWS; n++)
			issue_item(plan[n], 18);
		start <= 1'b0;

		// Drain, then give the block time to show any stray beat
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
